FILE: hw/rtl/ira_pkg.sv
`default_nettype none
package ira_pkg;
  localparam int unsigned TimeW = 32;
  localparam int unsigned RoomW = 7;
  typedef logic [TimeW-1:0] time_val_t;
  typedef logic [RoomW-1:0] room_t;
endpackage
`default_nettype wire

FILE: hw/rtl/interval_room_assigner.sv
// Greedy interval partitioning. Intervals load one transfer per cycle into
// start/end memories. After the transfer marked last the block sorts the
// stored indices by start time with a stable insertion sort. Each item walks
// toward the front by shift steps, and a compare stops the walk when it does
// not reach the front. For each interval in start order it then scans the
// open rooms' free times, one read a cycle, to find the earliest, and assigns;
// the scan makes at least one read, also when no room is open. Finally one
// result per stored interval is sent in input order, and the sink may hold
// tready low. No input is accepted from the last transfer until the final
// result transfer.
`default_nettype none
module interval_room_assigner #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // start_time, end_time
  input  wire logic        in_tlast,   // batch_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // room_number, room_total, overflow, 1'b0 fill
  output logic             out_tlast   // result_last
);
  import ira_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = AW + 1;

  typedef enum logic [3:0] {
    S_LOAD, S_SI, S_SRD, S_SNX, S_SO, S_SCMP, S_SPUT, S_AK, S_AKW, S_ASCAN,
    S_ADEC, S_ORD, S_OUT
  } state_t;

  state_t        state_r;
  logic [CW-1:0] cnt_r, i_r, j_r, r_r, rooms_r;
  logic [AW-1:0] best_r, v_r, k_r, ov_r;
  time_val_t     vs_r, best_t_r, ks_r, ke_r;
  logic          ovf_r;

  // memories
  logic          se_we, o_we, f_we, a_we;
  logic [AW-1:0] se_wa, s_ra, e_ra, o_wa, o_ra, f_wa, f_ra, a_ra;
  time_val_t     s_rd, e_rd, f_rd;
  logic [AW-1:0] o_rd, o_wd;
  room_t         a_rd, a_wd;

  ira_mem #(.Width(TimeW), .Depth(CAPACITY), .AddrW(AW)) u_start (
    .clk, .we(se_we), .waddr(se_wa), .wdata(in_tdata[31:0]), .raddr(s_ra), .rdata(s_rd));
  ira_mem #(.Width(TimeW), .Depth(CAPACITY), .AddrW(AW)) u_end (
    .clk, .we(se_we), .waddr(se_wa), .wdata(in_tdata[63:32]), .raddr(e_ra), .rdata(e_rd));
  ira_mem #(.Width(AW), .Depth(CAPACITY), .AddrW(AW)) u_order (
    .clk, .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));
  ira_mem #(.Width(TimeW), .Depth(CAPACITY), .AddrW(AW)) u_free (
    .clk, .we(f_we), .waddr(f_wa), .wdata(ke_r), .raddr(f_ra), .rdata(f_rd));
  ira_mem #(.Width(RoomW), .Depth(CAPACITY), .AddrW(AW)) u_assign (
    .clk, .we(a_we), .waddr(k_r), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));

  logic in_xfer, out_xfer, shift, reuse;
  assign in_tready = (state_r == S_LOAD);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;

  // load writes
  assign se_we = in_xfer && (cnt_r < CW'(CAPACITY));
  assign se_wa = cnt_r[AW-1:0];

  // shift step: order[j] takes order[j-1] while that start is later
  assign shift = (state_r == S_SCMP) && (s_rd > vs_r);
  // reuse the earliest-free room when the interval starts at or after it
  assign reuse = (rooms_r != '0) && (ks_r >= best_t_r);

  // read address steering and write ports
  always_comb begin
    s_ra = i_r[AW-1:0];
    e_ra = k_r;
    o_ra = AW'(j_r - CW'(1));
    f_ra = r_r[AW-1:0];
    a_ra = i_r[AW-1:0];
    o_we = (state_r == S_SPUT) || shift;
    o_wa = j_r[AW-1:0];
    o_wd = (state_r == S_SPUT) ? v_r : ov_r;
    f_we = (state_r == S_ADEC);
    f_wa = reuse ? best_r : rooms_r[AW-1:0];
    a_we = (state_r == S_ADEC);
    a_wd = reuse ? RoomW'(best_r) + RoomW'(1) : RoomW'(rooms_r) + RoomW'(1);
    case (state_r)
      S_SO: begin
        // order[j-1] arrived; read its start
        s_ra = o_rd;
      end
      S_AK: begin
        o_ra = i_r[AW-1:0];
      end
      S_AKW: begin
        s_ra = o_rd;
        e_ra = o_rd;
        f_ra = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0; rooms_r <= '0;
      out_tvalid <= 1'b0; i_r <= '0; j_r <= '0; r_r <= '0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_xfer) begin
            if (cnt_r < CW'(CAPACITY)) cnt_r <= cnt_r + CW'(1);
            else ovf_r <= 1'b1;
            if (in_tlast) begin
              i_r <= '0;
              state_r <= S_SI;
            end
          end
        end
        // insertion sort outer step; start[i] is read here
        S_SI: begin
          if (i_r == cnt_r) begin
            i_r <= '0; rooms_r <= '0;
            state_r <= S_AK;
          end else begin
            v_r <= i_r[AW-1:0];
            j_r <= i_r;
            state_r <= S_SRD;
          end
        end
        S_SRD: begin
          vs_r <= s_rd;
          state_r <= S_SNX;
        end
        // fetch order[j-1] unless at the front
        S_SNX: state_r <= (j_r == '0) ? S_SPUT : S_SO;
        S_SO: begin
          ov_r <= o_rd;
          state_r <= S_SCMP;
        end
        S_SCMP: begin
          if (shift) begin
            j_r <= j_r - CW'(1);
            state_r <= S_SNX;
          end else begin
            state_r <= S_SPUT;
          end
        end
        S_SPUT: begin
          i_r <= i_r + CW'(1);
          state_r <= S_SI;
        end
        // assignment: fetch order[i]
        S_AK: begin
          if (i_r == cnt_r) begin
            i_r <= '0;
            state_r <= S_ORD;
          end else begin
            state_r <= S_AKW;
          end
        end
        S_AKW: begin
          k_r <= o_rd;
          r_r <= CW'(1);
          state_r <= S_ASCAN;
        end
        // free time of room r-1 arrives; start/end of k on the first cycle
        S_ASCAN: begin
          if (r_r == CW'(1)) begin
            ks_r <= s_rd; ke_r <= e_rd;
          end
          if (rooms_r != '0 && (r_r == CW'(1) || f_rd < best_t_r)) begin
            best_t_r <= f_rd;
            best_r <= AW'(r_r - CW'(1));
          end
          if (r_r >= rooms_r) state_r <= S_ADEC;
          else r_r <= r_r + CW'(1);
        end
        S_ADEC: begin
          i_r <= i_r + CW'(1);
          if (!reuse) rooms_r <= rooms_r + CW'(1);
          state_r <= S_AK;
        end
        // assignment of entry i is registered and lands the cycle after its address
        S_ORD: begin
          out_tvalid <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_xfer) begin
            out_tvalid <= 1'b0;
            if (out_tlast) begin
              cnt_r <= '0; ovf_r <= 1'b0; rooms_r <= '0;
              state_r <= S_LOAD;
            end else begin
              i_r <= i_r + CW'(1);
              state_r <= S_ORD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  // output payload; address and counts hold while a result waits
  assign out_tdata = {1'b0, ovf_r, RoomW'(rooms_r), a_rd};
  assign out_tlast = (i_r + CW'(1) == cnt_r);
endmodule
`default_nettype wire

FILE: hw/rtl/ira_mem.sv
`default_nettype none
// Simple dual-port memory: one write port, one registered read port.
module ira_mem #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: tb/sv/interval_room_assigner_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module interval_room_assigner_tb;
  import ira_pkg::*;

  localparam int unsigned Cap = 64;

  // one expected room assignment
  typedef struct packed {
    room_t room;
    room_t total;
    logic  ovf;
    logic  last;
  } room_result_t;

  // Greedy room predictor plus queue of pending room results
  class room_scoreboard;
    time_val_t    starts[$];
    time_val_t    ends[$];
    logic         dropped;
    room_result_t pending[$];
    int           errors;

    function void note_interval(time_val_t s, time_val_t e, logic last);
      int unsigned order[$];
      time_val_t   free_at[$];
      room_t       given[Cap];
      int unsigned n, j, k, best;
      room_result_t r;
      if (starts.size() < Cap) begin
        starts.push_back(s);
        ends.push_back(e);
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;
      n = starts.size();
      // stable sort of indices by start time
      for (int unsigned i = 0; i < n; i++) begin
        j = 0;
        while (j < order.size() && starts[order[j]] <= starts[i]) j++;
        order.insert(j, i);
      end
      for (int unsigned i = 0; i < n; i++) begin
        k = order[i];
        best = 0;
        for (int unsigned q = 1; q < free_at.size(); q++)
          if (free_at[q] < free_at[best]) best = q;
        if (free_at.size() > 0 && starts[k] >= free_at[best]) begin
          free_at[best] = ends[k];
          given[k] = room_t'(best + 1);
        end else begin
          free_at.push_back(ends[k]);
          given[k] = room_t'(free_at.size());
        end
      end
      for (int unsigned i = 0; i < n; i++) begin
        r.room = given[i];
        r.total = room_t'(free_at.size());
        r.ovf = dropped;
        r.last = (i + 1 == n);
        pending.push_back(r);
      end
      starts.delete();
      ends.delete();
      dropped = 1'b0;
    endfunction

    task check_room(logic [15:0] data, logic last);
      room_result_t want;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      want = pending.pop_front();
      if (data[6:0] !== want.room) report("room_number mismatch");
      if (data[13:7] !== want.total) report("room_total mismatch");
      if (data[14] !== want.ovf) report("overflow mismatch");
      if (data[15] !== 1'b0) report("fill bit set");
      if (last !== want.last) report("result_last mismatch");
    endtask

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        calm = 1'b0;
  room_scoreboard rooms = new();

  interval_room_assigner #(.CAPACITY(Cap)) dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // sink: random stalls except in calm stretches
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) rooms.check_room(out_tdata, out_tlast);
    out_tready <= calm || ($urandom_range(99) >= 19);
  end

  // send one interval; random gap first
  task automatic send_interval(time_val_t s, time_val_t e, logic last);
    while (!calm && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {e, s};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    rooms.note_interval(s, e, last);
  endtask

  function automatic time_val_t rand_time(int unsigned span);
    if ($urandom_range(9) == 0) return $urandom();
    return $urandom_range(span);
  endfunction

  // batch of random intervals; mostly short durations to force reuse
  task automatic send_batch(int unsigned n, int unsigned span);
    time_val_t s, e;
    for (int unsigned i = 0; i < n; i++) begin
      s = rand_time(span);
      e = ($urandom_range(7) == 0) ? rand_time(span) : s + $urandom_range(span / 4 + 1);
      send_interval(s, e, i + 1 == n);
    end
  endtask

  int unsigned sent;

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: single interval, extremes, end before start, ties
    send_interval('0, '1, 1'b1);
    send_interval('1, '0, 1'b0);
    send_interval('0, '0, 1'b0);
    send_interval('1, '1, 1'b1);
    send_interval(32'd5, 32'd10, 1'b0);
    send_interval(32'd10, 32'd20, 1'b0);
    send_interval(32'd5, 32'd12, 1'b0);
    send_interval(32'd12, 32'd3, 1'b0);
    send_interval(32'd5, 32'd10, 1'b1);
    send_interval(32'd1, 32'd9, 1'b0);
    send_interval(32'd1, 32'd9, 1'b0);
    send_interval(32'd9, 32'd9, 1'b1);
    // full capacity plus dropped items, last one dropped too
    calm <= 1'b1;
    for (int unsigned i = 0; i < Cap + 3; i++)
      send_interval($urandom(), $urandom(), i == Cap + 2);
    // capacity exactly, all overlapping: 64 rooms
    for (int unsigned i = 0; i < Cap; i++)
      send_interval(time_val_t'(i), '1, i == Cap - 1);
    sent = 0;
    while (sent < 280) begin
      automatic int unsigned n = ($urandom_range(19) == 0) ? $urandom_range(Cap + 2, 40)
                                                            : $urandom_range(12, 1);
      calm <= (sent > 80 && sent < 150);
      send_batch(n, ($urandom_range(1)) ? 40 : 1000);
      sent += n;
    end
    calm <= 1'b0;
    in_tvalid <= 1'b0;
    while (rooms.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (rooms.errors == 0 && rooms.starts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/ira_pkg.sv
hw/rtl/ira_mem.sv
hw/rtl/interval_room_assigner.sv
tb/sv/interval_room_assigner_tb.sv
